// ===== hdl/line_segment_run_generator_assert.svh =====
// ----------------------------------------------------------------------------
// Line segment run generator assertion macros
// Shared concurrent-assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LINE_SEGMENT_RUN_GENERATOR_ASSERT_SVH
`define LINE_SEGMENT_RUN_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define LSRG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LSRG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lsrg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrg_pkg
// Widths, sequencer states and control types of the line segment run generator.
// ----------------------------------------------------------------------------
package lsrg_pkg;

  localparam int X_W        = 7;  // column width
  localparam int Y_W        = 5;  // row width
  localparam int COLOR_W    = 4;
  localparam int IDX_W      = 5;  // run index, at most 31
  localparam int DVSR_W     = 6;  // number of parts, at most 32
  localparam int DIV_CNT_W  = 3;  // one quotient bit per step over X_W bits

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MODE_SINGLE,
    MODE_DIAG,
    MODE_VMAJ,
    MODE_HMAJ
  } run_mode_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_start;
    logic emit;
  } lsrg_ctl_t;

  typedef struct packed {
    logic is_cut;
    logic div_done;
    logic last;
  } lsrg_stat_t;

endpackage

// ===== hdl/line_segment_run_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_segment_run_generator
// Breaks a line command into horizontal or vertical pixel runs.
// ----------------------------------------------------------------------------
// Usage:
//   A command (start_x, start_y, end_x, end_y, color) is taken in a transfer
//   at the rising edge where start is high and busy is low. busy stays high
//   until the last run of the line has been computed.
//   Each run leaves on run_x_begin .. run_color and last_run, with run_strobe
//   high for exactly one cycle; the receiver has no way to hold runs off, so
//   every run is a transfer in its strobe cycle. last_run marks the final run.
//   Sequence: a set-up state after the command transfer, then, for a line
//   that is neither a point, axis-aligned nor exactly 45 degrees, a
//   division in the shared restoring divider (major difference over
//   number of parts). Runs then come out one per cycle, each in the cycle
//   after it is computed. A line gives R runs, R from 1 to 32; a new
//   command may be taken in the cycle that shows the previous line's last
//   run.
//   Reset (rst, synchronous) returns the sequencer to idle and drops the
//   strobe; a command in progress is discarded.
// ----------------------------------------------------------------------------
module line_segment_run_generator #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [lsrg_pkg::X_W-1:0]     start_x,
  input  logic [lsrg_pkg::Y_W-1:0]     start_y,
  input  logic [lsrg_pkg::X_W-1:0]     end_x,
  input  logic [lsrg_pkg::Y_W-1:0]     end_y,
  input  logic [lsrg_pkg::COLOR_W-1:0] color,
  output logic                         run_strobe,
  output logic [lsrg_pkg::X_W-1:0]     run_x_begin,
  output logic [lsrg_pkg::Y_W-1:0]     run_y_begin,
  output logic [lsrg_pkg::X_W-1:0]     run_x_finish,
  output logic [lsrg_pkg::Y_W-1:0]     run_y_finish,
  output logic [lsrg_pkg::COLOR_W-1:0] run_color,
  output logic                         last_run
);
  import lsrg_pkg::*;

  `include "line_segment_run_generator_assert.svh"

  // Largest legal coordinate, limited to what the field width can carry, so
  // a screen wider than the field never clamps.
  localparam int XMAX_I = (SCREEN_WIDTH - 1 > 2**X_W - 1) ? 2**X_W - 1 : SCREEN_WIDTH - 1;
  localparam int YMAX_I = (SCREEN_HEIGHT - 1 > 2**Y_W - 1) ? 2**Y_W - 1 : SCREEN_HEIGHT - 1;
  localparam logic [X_W-1:0] XMAX = X_W'(XMAX_I);
  localparam logic [Y_W-1:0] YMAX = Y_W'(YMAX_I);

  lsrg_ctl_t  ctl;
  lsrg_stat_t stat;

  // Command registers, clamped on capture.
  logic [X_W-1:0]     sx;
  logic [Y_W-1:0]     sy;
  logic [X_W-1:0]     ex;
  logic [Y_W-1:0]     ey;
  logic [COLOR_W-1:0] col;

  // Walk registers.
  run_mode_t      mode;
  logic [X_W-1:0] cx;
  logic [Y_W-1:0] cy;
  logic           xneg;
  logic           yneg;
  logic [IDX_W-1:0] count;
  logic [IDX_W-1:0] last_idx;

  // Set-up decode, used in the cycle after capture.
  logic [X_W-1:0] dx;
  logic [Y_W-1:0] dy;
  run_mode_t      mode_prep;
  logic [X_W-1:0]    div_dividend;
  logic [DVSR_W-1:0] div_divisor;
  logic [X_W-1:0]    len;
  logic              div_done;

  // Emission datapath.
  logic [X_W-1:0] fin_x;
  logic [Y_W-1:0] fin_y;
  logic [X_W-1:0] cx_next;
  logic [Y_W-1:0] cy_next;
  logic [X_W-1:0] x_len_step;
  logic [Y_W-1:0] y_len_step;
  logic [X_W-1:0] x_one_step;
  logic [Y_W-1:0] y_one_step;
  logic           is_last;

  lsrg_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .ctl  (ctl),
    .busy (busy)
  );

  lsrg_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (ctl.div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(len)
  );

  // Capture the command, saturating coordinates that lie off the screen.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sx  <= (start_x > XMAX) ? XMAX : start_x;
      sy  <= (start_y > YMAX) ? YMAX : start_y;
      ex  <= (end_x > XMAX) ? XMAX : end_x;
      ey  <= (end_y > YMAX) ? YMAX : end_y;
      col <= color;
    end
  end

  // Classify the line: a point or axis-aligned line is one run, an exact
  // diagonal is a chain of single pixels, anything else is cut along its
  // major axis.
  always_comb begin
    dx = (sx > ex) ? sx - ex : ex - sx;
    dy = (sy > ey) ? sy - ey : ey - sy;
    if ((dx == '0) || (dy == '0)) begin
      mode_prep = MODE_SINGLE;
    end else if (dx == {{(X_W - Y_W){1'b0}}, dy}) begin
      mode_prep = MODE_DIAG;
    end else if ({{(X_W - Y_W){1'b0}}, dy} > dx) begin
      mode_prep = MODE_VMAJ;
    end else begin
      mode_prep = MODE_HMAJ;
    end
    // Run length is the major difference over (minor difference + 1).
    if (mode_prep == MODE_VMAJ) begin
      div_dividend = {{(X_W - Y_W){1'b0}}, dy};
      div_divisor  = DVSR_W'(dx[IDX_W-1:0]) + 1'b1;
    end else begin
      div_dividend = dx;
      div_divisor  = DVSR_W'(dy) + 1'b1;
    end
  end

  assign stat.is_cut   = (mode_prep == MODE_VMAJ) || (mode_prep == MODE_HMAJ);
  assign stat.div_done = div_done;
  assign stat.last     = is_last;
  assign is_last       = (count == last_idx);

  // Set the walk up in the prep cycle, then advance one run per emit cycle.
  always_ff @(posedge clk) begin
    if (ctl.prep) begin
      mode  <= mode_prep;
      count <= '0;
      unique case (mode_prep)
        MODE_SINGLE: begin
          last_idx <= '0;
          cx       <= sx;
          cy       <= sy;
          xneg     <= 1'b0;
          yneg     <= 1'b0;
        end
        MODE_DIAG: begin
          // Start from the end point with the smaller row, stepping down.
          last_idx <= dx[IDX_W-1:0];
          cx       <= (sy < ey) ? sx : ex;
          cy       <= (sy < ey) ? sy : ey;
          xneg     <= (sy < ey) ? !(sx < ex) : !(ex < sx);
          yneg     <= 1'b0;
        end
        MODE_VMAJ: begin
          last_idx <= dx[IDX_W-1:0];
          cx       <= sx;
          cy       <= sy;
          xneg     <= !(sx < ex);
          yneg     <= !(sy < ey);
        end
        MODE_HMAJ: begin
          last_idx <= dy;
          cx       <= sx;
          cy       <= sy;
          xneg     <= !(sx < ex);
          yneg     <= !(sy < ey);
        end
        default: begin
          last_idx <= '0;
          cx       <= sx;
          cy       <= sy;
          xneg     <= 1'b0;
          yneg     <= 1'b0;
        end
      endcase
    end else if (ctl.emit) begin
      count <= count + 1'b1;
      cx    <= cx_next;
      cy    <= cy_next;
    end
  end

  // Steps along each axis; all arithmetic wraps at the field width, which
  // matches the masked coordinates of the runs.
  always_comb begin
    x_len_step = xneg ? cx - len : cx + len;
    y_len_step = yneg ? cy - len[Y_W-1:0] : cy + len[Y_W-1:0];
    x_one_step = xneg ? cx - 1'b1 : cx + 1'b1;
    y_one_step = yneg ? cy - 1'b1 : cy + 1'b1;
  end

  always_comb begin
    unique case (mode)
      MODE_SINGLE: begin
        fin_x   = ex;
        fin_y   = ey;
        cx_next = cx;
        cy_next = cy;
      end
      MODE_DIAG: begin
        fin_x   = cx;
        fin_y   = cy;
        cx_next = x_one_step;
        cy_next = y_one_step;
      end
      MODE_VMAJ: begin
        // Vertical run; the last one is stretched to the end point.
        fin_x   = is_last ? ex : cx;
        fin_y   = is_last ? ey : y_len_step;
        cx_next = x_one_step;
        cy_next = y_len_step;
      end
      MODE_HMAJ: begin
        fin_x   = is_last ? ex : x_len_step;
        fin_y   = is_last ? ey : cy;
        cx_next = x_len_step;
        cy_next = y_one_step;
      end
      default: begin
        fin_x   = ex;
        fin_y   = ey;
        cx_next = cx;
        cy_next = cy;
      end
    endcase
  end

  // Result registers: the strobe is the only control bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_strobe <= 1'b0;
    end else begin
      run_strobe <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      run_x_begin  <= cx;
      run_y_begin  <= cy;
      run_x_finish <= fin_x;
      run_y_finish <= fin_y;
      run_color    <= col;
      last_run     <= is_last;
    end
  end

  // A run is only shown in the cycle after the sequencer produced it.
  `LSRG_ASSERT_IMP(a_strobe_from_emit, run_strobe, $past(ctl.emit), "run without emit cycle")
  // Once the last run is out, the block is free for the next command.
  `LSRG_ASSERT_IMP(a_last_frees, run_strobe && last_run, !busy, "busy after last run")
  // A run that is not the last one is always followed by more work.
  `LSRG_ASSERT_IMP(a_more_runs, run_strobe && !last_run, busy, "idle before last run")
  // An accepted command always starts the sequencer.
  `LSRG_ASSERT_NXT(a_accept_busy, start && !busy, busy && ctl.prep, "command not taken up")

endmodule

// ===== hdl/lsrg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrg_div
// Restoring divider, one quotient bit per cycle; the quotient holds after done.
// ----------------------------------------------------------------------------
module lsrg_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lsrg_pkg::X_W-1:0]    dividend,
  input  logic [lsrg_pkg::DVSR_W-1:0] divisor,
  output logic                        done,
  output logic [lsrg_pkg::X_W-1:0]    quotient
);
  import lsrg_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(X_W - 1);

  logic                  active;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DVSR_W-1:0]     rem;
  logic [DVSR_W-1:0]     divr;
  logic [DVSR_W:0]       rem_sh;
  logic [DVSR_W+1:0]     diff;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign rem_sh = {rem, quotient[X_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divr};
  assign done   = active && (cnt == CNT_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_LAST) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      divr     <= divisor;
      quotient <= dividend;
    end else if (active) begin
      if (!diff[DVSR_W+1]) begin
        rem      <= diff[DVSR_W-1:0];
        quotient <= {quotient[X_W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[DVSR_W-1:0];
        quotient <= {quotient[X_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hdl/lsrg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrg_ctrl
// Sequencer: capture, set-up, division and one run per cycle of emission.
// ----------------------------------------------------------------------------
module lsrg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  lsrg_pkg::lsrg_stat_t stat,
  output lsrg_pkg::lsrg_ctl_t  ctl,
  output logic                 busy
);
  import lsrg_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = stat.is_cut ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        if (stat.div_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy          = (state != ST_IDLE);
    ctl.load      = (state == ST_IDLE) && start;
    ctl.prep      = (state == ST_PREP);
    ctl.div_start = (state == ST_PREP) && stat.is_cut;
    ctl.emit      = (state == ST_EMIT);
  end

endmodule
